// ===== sv/vtan_pkg.sv =====
`timescale 1ns / 1ps
package vtan_pkg;
   localparam int QW = 16;
   localparam logic [QW-1:0] ONE_Q14 = 16'd16384;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } div_ctl_type;
endpackage

// ===== sv/vtan_seq_unit.sv =====
`timescale 1ns / 1ps
module vtan_seq_unit
   import vtan_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] result
);
   // shared shift/subtract engine: 2 radicand bits for sqrt or 1 bit of quotient per cycle
   // sqrt: 32 steps over a 64-bit radicand; divide: 45 steps, num < 2^45
   logic [63:0] src_ff, src_in;   // operand bits still to come, msb first
   logic [35:0] acc_ff, acc_in;   // partial remainder
   logic [31:0] res_ff, res_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, mode_ff, mode_in, done_ff;
   logic [31:0] den_ff, den_in;
   logic [35:0] shifted, subtrahend, trial;

   always_comb begin
      src_in = src_ff; acc_in = acc_ff; res_in = res_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; mode_in = mode_ff; den_in = den_ff;
      if (mode_ff) begin
         shifted = {acc_ff[33:0], src_ff[63:62]};
         subtrahend = {2'b00, res_ff, 2'b01};
      end else begin
         shifted = {acc_ff[34:0], src_ff[63]};
         subtrahend = {4'd0, den_ff};
      end
      trial = shifted - subtrahend;
      if (ctl.start) begin
         acc_in = '0; res_in = '0; busy_in = 1'b1;
         mode_in = ctl.sqrt_mode; den_in = den;
         src_in = ctl.sqrt_mode ? num : {num[44:0], 19'd0};
         cnt_in = ctl.sqrt_mode ? 6'd31 : 6'd44;
      end else if (busy_ff) begin
         src_in = mode_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         if (!trial[35]) begin
            acc_in = trial;
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            acc_in = shifted;
            res_in = {res_ff[30:0], 1'b0};
         end
         if (cnt_ff == '0) busy_in = 1'b0;
         else cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         done_ff <= busy_ff && (cnt_ff == '0);
      end
      src_ff <= src_in; acc_ff <= acc_in; res_ff <= res_in;
      mode_ff <= mode_in; den_ff <= den_in;
   end

   // result is final in the cycle done is high
   assign done = done_ff;
   assign result = res_ff;
endmodule

// ===== sv/vertex_tangent_from_uv.sv =====
`timescale 1ns / 1ps
// channel  | direction | ports
// request  | in        | req_valid, req_stall, req_pos_*, req_tex_*, req_ring_start
// response | out       | rsp_valid, rsp_stall, rsp_tan_*, rsp_degenerate
// A request that completes a window of three is finished before the next accept:
// products and sums go through one signed 33x33 multiplier, the magnitudes are
// normalized by single-bit shifts, then a shared shift/subtract unit runs a
// 32-step square root and three 45-step divides. A degenerate window skips the
// square root and divides; other requests only shift the window. Synchronous reset
// clears the window. A waiting response holds the block while rsp_stall is high.
module vertex_tangent_from_uv
   import vtan_pkg::*;
#(
   parameter int POS_WIDTH = 24,
   parameter int UV_WIDTH  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_WIDTH-1:0] req_pos_x,
   input  logic signed [POS_WIDTH-1:0] req_pos_y,
   input  logic signed [POS_WIDTH-1:0] req_pos_z,
   input  logic signed [UV_WIDTH-1:0]  req_tex_u,
   input  logic signed [UV_WIDTH-1:0]  req_tex_v,
   input  logic                        req_ring_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [QW-1:0]        rsp_tan_x,
   output logic signed [QW-1:0]        rsp_tan_y,
   output logic signed [QW-1:0]        rsp_tan_z,
   output logic                        rsp_degenerate
);
   localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_NORM = 4'd2,
      S_SQ = 4'd3, S_SQRT = 4'd4, S_DIV = 4'd5, S_OUT = 4'd6, S_SHIFT = 4'd7;

   logic [3:0] st_ff, st_in;
   logic [1:0] fill_ff;
   logic signed [POS_WIDTH-1:0] op_ff [3], mp_ff [3], np_ff [3];
   logic signed [UV_WIDTH-1:0]  ot_ff [2], mt_ff [2], nt_ff [2];
   // deltas: at most 33 bits, products < 2^63
   logic signed [32:0] dp1_ff [3], dp2_ff [3];
   logic signed [32:0] du1, dv1, du2, dv2;
   logic signed [63:0] c_ff [3], det_ff;
   logic [63:0] a_ff [3];
   logic [63:0] sum_ff;
   logic [3:0] step_ff;
   logic [1:0] idx_ff;
   logic signed [63:0] prod;
   logic signed [32:0] ma, mb;
   logic [63:0] mx;
   logic [31:0] len_ff;
   logic [15:0] q_ff [3];
   logic deg_ff;
   div_ctl_type ctl;
   logic [63:0] u_num;
   logic u_done;
   logic [31:0] u_res;

   vtan_seq_unit u_seq (.clock, .reset, .ctl, .num(u_num), .den(len_ff),
      .done(u_done), .result(u_res));

   assign du1 = 33'(nt_ff[0]) - 33'(mt_ff[0]);
   assign dv1 = 33'(nt_ff[1]) - 33'(mt_ff[1]);
   assign du2 = 33'(ot_ff[0]) - 33'(mt_ff[0]);
   assign dv2 = 33'(ot_ff[1]) - 33'(mt_ff[1]);

   // one multiplier: step picks operands, squares share it
   always_comb begin
      ma = '0; mb = '0;
      if (st_ff == S_SQ) begin
         // normalized magnitudes are below 2^30
         ma = {3'b000, a_ff[idx_ff][29:0]};
         mb = {3'b000, a_ff[idx_ff][29:0]};
      end else begin
         case (step_ff)
            4'd0: begin ma = du1; mb = dv2; end
            4'd1: begin ma = du2; mb = dv1; end
            4'd2, 4'd4, 4'd6: begin ma = dv2; mb = dp1_ff[step_ff[2:1]-2'd1]; end
            4'd3, 4'd5, 4'd7: begin ma = dv1; mb = dp2_ff[step_ff[2:1]-2'd1]; end
            default: begin ma = '0; mb = '0; end
         endcase
      end
      prod = ma * mb;
   end

   always_comb begin
      mx = a_ff[0];
      if (a_ff[1] > mx) mx = a_ff[1];
      if (a_ff[2] > mx) mx = a_ff[2];
   end

   always_comb begin
      ctl = '0;
      u_num = '0;
      if (st_ff == S_SQRT && step_ff == 4'd0) begin
         ctl.start = 1'b1; ctl.sqrt_mode = 1'b1; u_num = sum_ff;
      end else if (st_ff == S_DIV && step_ff == 4'd0) begin
         ctl.start = 1'b1;
         // rounded quotient: (a << 14) + len/2, below 2^45
         u_num = ({a_ff[idx_ff][49:0], 14'd0}) + {33'd0, len_ff[31:1]};
      end
   end

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:  if (req_valid) st_in = S_SHIFT;
         default: st_in = st_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         fill_ff <= '0;
         step_ff <= '0;
         idx_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            op_ff[i] <= '0; mp_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            ot_ff[i] <= '0; mt_ff[i] <= '0;
         end
      end else begin
         case (st_ff)
            S_IDLE: if (req_valid) begin
               np_ff[0] <= req_pos_x; np_ff[1] <= req_pos_y; np_ff[2] <= req_pos_z;
               nt_ff[0] <= req_tex_u; nt_ff[1] <= req_tex_v;
               if (req_ring_start) fill_ff <= '0;
               if (req_ring_start || fill_ff != 2'd2) st_ff <= S_SHIFT;
               else begin
                  st_ff <= S_MUL;
                  step_ff <= 4'd15;
               end
            end
            S_MUL: begin
               if (step_ff == 4'd15) begin
                  for (int i = 0; i < 3; i++) begin
                     dp1_ff[i] <= 33'(np_ff[i]) - 33'(mp_ff[i]);
                     dp2_ff[i] <= 33'(op_ff[i]) - 33'(mp_ff[i]);
                  end
                  step_ff <= 4'd0;
               end else begin
                  case (step_ff)
                     4'd0: det_ff <= prod;
                     4'd1: det_ff <= det_ff - prod;
                     4'd2: c_ff[0] <= prod;
                     4'd3: c_ff[0] <= c_ff[0] - prod;
                     4'd4: c_ff[1] <= prod;
                     4'd5: c_ff[1] <= c_ff[1] - prod;
                     4'd6: c_ff[2] <= prod;
                     4'd7: c_ff[2] <= c_ff[2] - prod;
                     default: ;
                  endcase
                  if (step_ff == 4'd8) begin
                     for (int i = 0; i < 3; i++)
                        a_ff[i] <= c_ff[i][63] ? 64'(-c_ff[i]) : 64'(c_ff[i]);
                     st_ff <= S_NORM;
                  end
                  step_ff <= step_ff + 4'd1;
               end
            end
            S_NORM: begin
               // one bit of shift per cycle
               if (det_ff == 0 || mx == 0) begin
                  deg_ff <= 1'b1;
                  for (int i = 0; i < 3; i++) q_ff[i] <= '0;
                  st_ff <= S_OUT;
               end else if (mx >= 64'd1 << 30) begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] >> 1;
               end else if (mx < 64'd1 << 29) begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] << 1;
               end else begin
                  deg_ff <= 1'b0; sum_ff <= '0; idx_ff <= '0; st_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sum_ff <= sum_ff + prod;
               if (idx_ff == 2'd2) begin
                  step_ff <= '0;
                  st_ff <= S_SQRT;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_SQRT: begin
               if (step_ff == 4'd0) step_ff <= 4'd1;
               else if (u_done) begin
                  len_ff <= u_res; idx_ff <= '0; step_ff <= '0; st_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (step_ff == 4'd0) step_ff <= 4'd1;
               else if (u_done) begin
                  q_ff[idx_ff] <= (c_ff[idx_ff][63] != det_ff[63]) ?
                     16'(-u_res[15:0]) : u_res[15:0];
                  step_ff <= '0;
                  if (idx_ff == 2'd2) st_ff <= S_OUT;
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_OUT: if (!rsp_stall) st_ff <= S_SHIFT;
            S_SHIFT: begin
               for (int i = 0; i < 3; i++) begin
                  op_ff[i] <= mp_ff[i]; mp_ff[i] <= np_ff[i];
               end
               for (int i = 0; i < 2; i++) begin
                  ot_ff[i] <= mt_ff[i]; mt_ff[i] <= nt_ff[i];
               end
               if (fill_ff != 2'd2) fill_ff <= fill_ff + 2'd1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= st_in;
         endcase
      end
   end

   assign rsp_tan_x = q_ff[0];
   assign rsp_tan_y = q_ff[1];
   assign rsp_tan_z = q_ff[2];
   assign rsp_degenerate = deg_ff;
endmodule
